// ===== rtl/rqom_pkg.sv =====
// Shared types, codes and defaults for the recursive quadrature oscillator mixer.
`default_nettype none

package rqom_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CFG_INDEX_W      = 3;
  localparam int STEP_W           = 4;

  // Last microcode step of each sequence
  localparam logic [STEP_W-1:0] LAST_STEP_MIX  = 4'd15;
  localparam logic [STEP_W-1:0] LAST_STEP_TONE = 4'd13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COS_STEP  = 3'd0,
    REG_SIN_STEP  = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_TEST_MODE = 3'd3,
    REG_REAL_ONLY = 3'd4,
    REG_BYPASS    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_BYPASS,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OPA_PR,
    OPA_PI,
    OPA_SMP_A,
    OPA_SMP_B,
    OPA_GAIN,
    OPA_MIX_RE,
    OPA_MIX_IM,
    OPA_OSC_RE,
    OPA_OSC_IM
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_CS,
    OPB_SN,
    OPB_PR,
    OPB_PI,
    OPB_OSC_RE,
    OPB_OSC_IM,
    OPB_AMP
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    RSRC_ACC,
    RSRC_MIX_RE,
    RSRC_MIX_IM
  } rnd_src_t;

  typedef enum logic {
    RSH_FRAC,
    RSH_TONE
  } rnd_shift_t;

  typedef enum logic [1:0] {
    LIM_NONE,
    LIM_PHASOR,
    LIM_MIX,
    LIM_OUT
  } rnd_lim_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_OSC_RE,
    DST_OSC_IM,
    DST_GAIN,
    DST_MIX_RE,
    DST_MIX_IM,
    DST_PR,
    DST_PI,
    DST_RES_RE,
    DST_RES_IM
  } rnd_dst_t;

  typedef struct packed {
    opa_sel_t   opa;
    opb_sel_t   opb;
    acc_op_t    acc_op;
    rnd_src_t   rnd_src;
    rnd_shift_t rnd_shift;
    rnd_lim_t   rnd_lim;
    rnd_dst_t   rnd_dst;
    logic       capture;
    logic       load_bypass;
    logic       push;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic test_mode;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rqom_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate datapath through one sample.
`default_nettype none

module rqom_ctrl
  import rqom_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [STEP_W-1:0] last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign last_step = status.test_mode ? LAST_STEP_TONE : LAST_STEP_MIX;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    step_next       = step;
    cmd.opa         = OPA_PR;
    cmd.opb         = OPB_CS;
    cmd.acc_op      = ACC_HOLD;
    cmd.rnd_src     = RSRC_ACC;
    cmd.rnd_shift   = RSH_FRAC;
    cmd.rnd_lim     = LIM_NONE;
    cmd.rnd_dst     = DST_NONE;
    cmd.capture     = 1'b0;
    cmd.load_bypass = 1'b0;
    cmd.push        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.bypass ? ST_BYPASS : ST_RUN;
        end
      end

      ST_BYPASS: begin
        cmd.load_bypass = 1'b1;
        state_next      = ST_DONE;
      end

      ST_RUN: begin
        step_next = step + 1'b1;
        if (step == last_step) begin
          state_next = ST_DONE;
        end
        // Rotation and magnitude share steps 0..5 in both sequences
        if (!status.test_mode) begin
          unique case (step)
            4'd0: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_CS;
            end
            4'd1: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_SN; cmd.acc_op = ACC_LOAD;
            end
            4'd2: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_CS; cmd.acc_op = ACC_SUB;
            end
            4'd3: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_SN; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_OSC_RE; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd4: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_PR; cmd.acc_op = ACC_ADD;
            end
            4'd5: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_PI; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_OSC_IM; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd6: begin
              cmd.opa = OPA_SMP_A; cmd.opb = OPB_OSC_RE; cmd.acc_op = ACC_ADD;
            end
            4'd7: begin
              cmd.opa = OPA_SMP_B; cmd.opb = OPB_OSC_IM; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_GAIN;
            end
            4'd8: begin
              cmd.opa = OPA_SMP_A; cmd.opb = OPB_OSC_IM; cmd.acc_op = ACC_SUB;
            end
            4'd9: begin
              cmd.opa = OPA_SMP_B; cmd.opb = OPB_OSC_RE; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_MIX_RE; cmd.rnd_lim = LIM_MIX;
            end
            4'd10: begin
              cmd.opa = OPA_GAIN; cmd.opb = OPB_OSC_RE; cmd.acc_op = ACC_ADD;
            end
            4'd11: begin
              cmd.opa = OPA_GAIN; cmd.opb = OPB_OSC_IM; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_MIX_IM; cmd.rnd_lim = LIM_MIX;
            end
            4'd12: begin
              cmd.opa = OPA_MIX_RE; cmd.opb = OPB_AMP; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_PR; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd13: begin
              cmd.opa = OPA_MIX_IM; cmd.opb = OPB_AMP; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_PI; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd14: begin
              cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_RES_RE; cmd.rnd_lim = LIM_OUT;
            end
            default: begin
              cmd.rnd_dst = DST_RES_IM; cmd.rnd_lim = LIM_OUT;
            end
          endcase
        end else begin
          unique case (step)
            4'd0: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_CS;
            end
            4'd1: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_SN; cmd.acc_op = ACC_LOAD;
            end
            4'd2: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_CS; cmd.acc_op = ACC_SUB;
            end
            4'd3: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_SN; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_OSC_RE; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd4: begin
              cmd.opa = OPA_PR; cmd.opb = OPB_PR; cmd.acc_op = ACC_ADD;
            end
            4'd5: begin
              cmd.opa = OPA_PI; cmd.opb = OPB_PI; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_OSC_IM; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd6: begin
              cmd.opa = OPA_OSC_RE; cmd.opb = OPB_AMP; cmd.acc_op = ACC_ADD;
            end
            4'd7: begin
              cmd.opa = OPA_OSC_IM; cmd.opb = OPB_AMP; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_GAIN;
            end
            // Tone values park in the mix registers until the final scaling
            4'd8: begin
              cmd.opa = OPA_GAIN; cmd.opb = OPB_OSC_RE; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_MIX_RE;
            end
            4'd9: begin
              cmd.opa = OPA_GAIN; cmd.opb = OPB_OSC_IM; cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_MIX_IM;
            end
            4'd10: begin
              cmd.acc_op = ACC_LOAD;
              cmd.rnd_dst = DST_PR; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd11: begin
              cmd.rnd_dst = DST_PI; cmd.rnd_lim = LIM_PHASOR;
            end
            4'd12: begin
              cmd.rnd_src = RSRC_MIX_RE; cmd.rnd_shift = RSH_TONE;
              cmd.rnd_dst = DST_RES_RE; cmd.rnd_lim = LIM_OUT;
            end
            default: begin
              cmd.rnd_src = RSRC_MIX_IM; cmd.rnd_shift = RSH_TONE;
              cmd.rnd_dst = DST_RES_IM; cmd.rnd_lim = LIM_OUT;
            end
          endcase
        end
      end

      ST_DONE: begin
        // Hold the result until the output register is free
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rqom_datapath.sv =====
// Shared multiplier, accumulator, rounding unit, oscillator state and output register.
`default_nettype none

module rqom_datapath
  import rqom_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_cmd_t                        cmd,
  output dp_status_t                     status,
  input  logic                           cfg_write,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [FRAC_BITS+1:0]           cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im
);

  localparam int PW    = FRAC_BITS + 2;
  localparam int AW    = FRAC_BITS + 1;
  localparam int GW    = FRAC_BITS + 5;
  localparam int MW    = (SAMPLE_WIDTH > FRAC_BITS) ? SAMPLE_WIDTH + 3 : FRAC_BITS + 3;
  localparam int OPW   = (FRAC_BITS + 5 > SAMPLE_WIDTH + 3) ? FRAC_BITS + 5 : SAMPLE_WIDTH + 3;
  localparam int PRODW = 2 * OPW;
  localparam int ACCW  = PRODW + 1;

  localparam bit TONE_UP  = (SAMPLE_WIDTH - 1 >= FRAC_BITS);
  localparam int TONE_LSH = TONE_UP ? SAMPLE_WIDTH - 1 - FRAC_BITS : 0;
  localparam int TONE_RSH = TONE_UP ? 1 : FRAC_BITS - SAMPLE_WIDTH + 1;

  localparam longint GAIN_K_L = ((longint'(195) <<< FRAC_BITS) + 50) / 100;
  localparam logic signed [GW-1:0] GAIN_K = GW'(GAIN_K_L);

  localparam logic signed [PW-1:0] ONE_S = PW'(longint'(1) <<< FRAC_BITS);
  localparam logic signed [PW-1:0] MONE_S = -ONE_S;
  localparam logic [AW-1:0] ONE_U = AW'(longint'(1) <<< FRAC_BITS);

  localparam logic signed [ACCW-1:0] HALF_F    = ACCW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [ACCW-1:0] HALF_F_M1 = HALF_F - ACCW'(longint'(1));
  localparam logic signed [ACCW-1:0] HALF_T    = ACCW'(longint'(1) <<< (TONE_RSH - 1));
  localparam logic signed [ACCW-1:0] HALF_T_M1 = HALF_T - ACCW'(longint'(1));

  localparam logic signed [ACCW-1:0] PH_MAX  =
    ACCW'((longint'(1) <<< (FRAC_BITS + 1)) - longint'(1));
  localparam logic signed [ACCW-1:0] MIX_MAX = ACCW'(longint'(1) <<< (SAMPLE_WIDTH + 1));
  localparam logic signed [ACCW-1:0] OUT_MAX =
    ACCW'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
  localparam logic signed [ACCW-1:0] OUT_MIN = ACCW'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

  // Configuration
  logic signed [PW-1:0] cos_step, sin_step;
  logic [AW-1:0]        amplitude;
  logic                 test_mode, real_only, bypass;

  // Oscillator state and working registers
  logic signed [PW-1:0]           pr, pi;
  logic signed [PW-1:0]           osc_re, osc_im;
  logic signed [GW-1:0]           gain;
  logic signed [MW-1:0]           mix_re, mix_im;
  logic signed [SAMPLE_WIDTH-1:0] smp_a, smp_b;
  logic signed [SAMPLE_WIDTH-1:0] res_re, res_im;

  logic signed [OPW-1:0]   opa, opb;
  logic signed [PRODW-1:0] prod;
  logic signed [ACCW-1:0]  acc;

  logic signed [PW-1:0]   cfg_s, cfg_step_clamped;
  logic [AW-1:0]          cfg_amp_clamped;

  logic signed [ACCW-1:0] rin, rsum_f, rsum_t, rshifted, rclamp, lim_hi, lim_lo;
  logic                   rneg, clamp_en;
  logic                   out_free;

  // Configuration write with range clamping
  assign cfg_s            = $signed(cfg_data);
  assign cfg_step_clamped = (cfg_s > ONE_S) ? ONE_S : ((cfg_s < MONE_S) ? MONE_S : cfg_s);
  assign cfg_amp_clamped  = (cfg_data[AW-1:0] > ONE_U) ? ONE_U : cfg_data[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_step  <= ONE_S;
      sin_step  <= '0;
      amplitude <= ONE_U;
      test_mode <= 1'b0;
      real_only <= 1'b0;
      bypass    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COS_STEP:  cos_step  <= cfg_step_clamped;
        REG_SIN_STEP:  sin_step  <= cfg_step_clamped;
        REG_AMPLITUDE: amplitude <= cfg_amp_clamped;
        REG_TEST_MODE: test_mode <= cfg_data[0];
        REG_REAL_ONLY: real_only <= cfg_data[0];
        REG_BYPASS:    bypass    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Operand selection into the shared multiplier
  always_comb begin
    unique case (cmd.opa)
      OPA_PR:     opa = OPW'(pr);
      OPA_PI:     opa = OPW'(pi);
      OPA_SMP_A:  opa = OPW'(smp_a);
      OPA_SMP_B:  opa = OPW'(smp_b);
      OPA_GAIN:   opa = OPW'(gain);
      OPA_MIX_RE: opa = OPW'(mix_re);
      OPA_MIX_IM: opa = OPW'(mix_im);
      OPA_OSC_RE: opa = OPW'(osc_re);
      OPA_OSC_IM: opa = OPW'(osc_im);
      default:    opa = '0;
    endcase
    unique case (cmd.opb)
      OPB_CS:     opb = OPW'(cos_step);
      OPB_SN:     opb = OPW'(sin_step);
      OPB_PR:     opb = OPW'(pr);
      OPB_PI:     opb = OPW'(pi);
      OPB_OSC_RE: opb = OPW'(osc_re);
      OPB_OSC_IM: opb = OPW'(osc_im);
      OPB_AMP:    opb = $signed(OPW'(amplitude));
      default:    opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    unique case (cmd.acc_op)
      ACC_HOLD: acc <= acc;
      ACC_LOAD: acc <= ACCW'(prod);
      ACC_ADD:  acc <= acc + ACCW'(prod);
      ACC_SUB:  acc <= acc - ACCW'(prod);
      default:  acc <= acc;
    endcase
  end

  // Round half away from zero: bias by half (minus one when negative), then shift
  always_comb begin
    unique case (cmd.rnd_src)
      RSRC_ACC:    rin = acc;
      RSRC_MIX_RE: rin = ACCW'(mix_re);
      RSRC_MIX_IM: rin = ACCW'(mix_im);
      default:     rin = acc;
    endcase
    rneg   = rin[ACCW-1];
    rsum_f = rin + (rneg ? HALF_F_M1 : HALF_F);
    rsum_t = rin + (rneg ? HALF_T_M1 : HALF_T);
    if (cmd.rnd_shift == RSH_FRAC) begin
      rshifted = rsum_f >>> FRAC_BITS;
    end else if (TONE_UP) begin
      rshifted = rin <<< TONE_LSH;
    end else begin
      rshifted = rsum_t >>> TONE_RSH;
    end

    clamp_en = 1'b1;
    unique case (cmd.rnd_lim)
      LIM_PHASOR: begin
        lim_hi = PH_MAX;  lim_lo = -PH_MAX;
      end
      LIM_MIX: begin
        lim_hi = MIX_MAX; lim_lo = -MIX_MAX;
      end
      LIM_OUT: begin
        lim_hi = OUT_MAX; lim_lo = OUT_MIN;
      end
      default: begin
        lim_hi = OUT_MAX; lim_lo = OUT_MIN; clamp_en = 1'b0;
      end
    endcase
    priority if (clamp_en && (rshifted > lim_hi)) begin
      rclamp = lim_hi;
    end else if (clamp_en && (rshifted < lim_lo)) begin
      rclamp = lim_lo;
    end else begin
      rclamp = rshifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr <= ONE_S;
      pi <= '0;
    end else begin
      unique case (cmd.rnd_dst)
        DST_PR:  pr <= $signed(rclamp[PW-1:0]);
        DST_PI:  pi <= $signed(rclamp[PW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_a <= in_re;
      smp_b <= real_only ? '0 : in_im;
    end
    if (cmd.load_bypass) begin
      res_re <= smp_a;
      res_im <= smp_b;
    end
    unique case (cmd.rnd_dst)
      DST_OSC_RE: osc_re <= $signed(rclamp[PW-1:0]);
      DST_OSC_IM: osc_im <= $signed(rclamp[PW-1:0]);
      DST_GAIN:   gain   <= GAIN_K - $signed(rclamp[GW-1:0]);
      DST_MIX_RE: mix_re <= $signed(rclamp[MW-1:0]);
      DST_MIX_IM: mix_im <= $signed(rclamp[MW-1:0]);
      DST_RES_RE: res_re <= $signed(rclamp[SAMPLE_WIDTH-1:0]);
      DST_RES_IM: res_im <= $signed(rclamp[SAMPLE_WIDTH-1:0]);
      default: ;
    endcase
  end

  // Output register: the next sample can start while a result waits here
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_re <= res_re;
      out_im <= real_only ? '0 : res_im;
    end
  end

  assign status.bypass    = bypass;
  assign status.test_mode = test_mode;
  assign status.out_free  = out_free;

endmodule

`default_nettype wire

// ===== rtl/recursive_quadrature_oscillator_mixer_core.sv =====
// Recursive quadrature oscillator with gain correction and I/Q mixer, top level.
// In mix and tone mode the microcode sequence steps each sample through the one shared
// multiplier and its accumulator, one product per cycle; bypass skips it. out_valid rises when
// the result is pushed into the output register, and the next sample is accepted after that push.
// Reset (synchronous, rst high): cos_step one, sin_step zero, amplitude one, bypass on,
// phasor at one, output register empty.
`default_nettype none

module recursive_quadrature_oscillator_mixer_core
  import rqom_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [FRAC_BITS+1:0]           cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rqom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rqom_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_re     (in_re),
    .in_im     (in_im),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_re    (out_re),
    .out_im    (out_im)
  );

endmodule

`default_nettype wire

// ===== verif/rqom_mix_checker.sv =====
// Checker for the oscillator mixer: follows register writes, predicts each sample, compares.
`timescale 1ns / 100ps

module rqom_mix_checker
  import rqom_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [CFG_INDEX_W-1:0]              cfg_index,
  input  logic [FRAC_BITS_DEF+1:0]            cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  in_re,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  in_im,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  out_re,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  out_im,
  output int                                  pending,
  output int                                  mismatches
);

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE_Q    = longint'(1) << FB;
  localparam longint PH_LIM   = (longint'(1) << (FB + 1)) - 1;
  localparam longint MIX_LIM  = longint'(1) << (SW + 1);
  localparam longint OUT_MAX  = (longint'(1) << (SW - 1)) - 1;
  localparam longint OUT_MIN  = -(longint'(1) << (SW - 1));
  localparam longint WIDE_LIM = longint'(1) << 62;
  localparam longint GAIN_K   = ((longint'(195) << FB) + 50) / 100;
  localparam int MAX_PRINTS   = 100;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } iq_t;

  iq_t    mixed_samples[$];
  iq_t    want;
  longint cos_q, sin_q, amp_q;
  longint ph_re, ph_im;
  bit     tone_on, real_on, pass_on;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  function automatic longint unsigned mag_of(input longint x);
    return (x < 0) ? $unsigned(-x) : $unsigned(x);
  endfunction

  // Round the magnitude half away from zero, limit it, then restore the sign.
  function automatic longint rnd_mag(input longint unsigned u, input bit neg, input int sh,
                                     input longint lim);
    longint unsigned m;
    m = u;
    if (sh > 0) m = ((m >> (sh - 1)) + 1) >> 1;
    if (m > $unsigned(lim)) m = $unsigned(lim);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic longint shift_rnd(input longint x, input int sh, input longint lim);
    return rnd_mag(mag_of(x), x < 0, sh, lim);
  endfunction

  function automatic longint mul_rnd(input longint a, input longint b, input int sh,
                                     input longint lim);
    return rnd_mag(mag_of(a) * mag_of(b), (a < 0) != (b < 0), sh, lim);
  endfunction

  function automatic logic signed [SW-1:0] to_sample(input longint x);
    longint c;
    c = (x < OUT_MIN) ? OUT_MIN : ((x > OUT_MAX) ? OUT_MAX : x);
    return c[SW-1:0];
  endfunction

  function automatic longint limit_step(input longint s);
    return (s < -ONE_Q) ? -ONE_Q : ((s > ONE_Q) ? ONE_Q : s);
  endfunction

  // Full scale of the phasor maps onto the top of the sample range.
  function automatic longint tone_level(input longint osc);
    longint t;
    t = mul_rnd(osc, amp_q, FB, WIDE_LIM);
    if (SW - 1 >= FB) return t * (longint'(1) << ((SW - 1 >= FB) ? SW - 1 - FB : 0));
    return shift_rnd(t, FB - SW + 1, WIDE_LIM);
  endfunction

  function automatic iq_t oscillate_and_mix(input longint a, input longint b_raw);
    longint b, ore, oim, mag, g, mre, mim;
    iq_t    r;
    b = real_on ? 0 : b_raw;
    if (pass_on) begin
      r.re = a[SW-1:0];
      r.im = b[SW-1:0];
      return r;
    end
    ore = shift_rnd(ph_re * cos_q - ph_im * sin_q, FB, PH_LIM);
    oim = shift_rnd(ph_im * cos_q + ph_re * sin_q, FB, PH_LIM);
    mag = shift_rnd(ph_re * ph_re + ph_im * ph_im, FB, WIDE_LIM);
    g = GAIN_K - mag;
    ph_re = mul_rnd(g, ore, FB, PH_LIM);
    ph_im = mul_rnd(g, oim, FB, PH_LIM);
    if (tone_on) begin
      r.re = to_sample(tone_level(ore));
      r.im = real_on ? '0 : to_sample(tone_level(oim));
    end else if (real_on) begin
      mre = shift_rnd(a * ore, FB, MIX_LIM);
      r.re = to_sample(mul_rnd(mre, amp_q, FB, WIDE_LIM));
      r.im = '0;
    end else begin
      // both products use the sample as it arrived
      mre = shift_rnd(a * ore - b * oim, FB, MIX_LIM);
      mim = shift_rnd(a * oim + b * ore, FB, MIX_LIM);
      r.re = to_sample(mul_rnd(mre, amp_q, FB, WIDE_LIM));
      r.im = to_sample(mul_rnd(mim, amp_q, FB, WIDE_LIM));
    end
    return r;
  endfunction

  function automatic void take_write(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [FB+1:0] val);
    longint s;
    s = longint'($signed(val));
    case (idx)
      REG_COS_STEP:  cos_q = limit_step(s);
      REG_SIN_STEP:  sin_q = limit_step(s);
      REG_AMPLITUDE: begin
        amp_q = longint'(val[FB:0]);
        if (amp_q > ONE_Q) amp_q = ONE_Q;
      end
      REG_TEST_MODE: tone_on = val[0];
      REG_REAL_ONLY: real_on = val[0];
      REG_BYPASS:    pass_on = val[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (mismatches < MAX_PRINTS)
      $display("%0t rqom check: %s got %0d expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cos_q   = ONE_Q;
      sin_q   = 0;
      amp_q   = ONE_Q;
      tone_on = 1'b0;
      real_on = 1'b0;
      pass_on = 1'b1;
      ph_re   = ONE_Q;
      ph_im   = 0;
      mixed_samples.delete();
      pending = 0;
    end else begin
      if (cfg_write) take_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) mixed_samples.push_back(oscillate_and_mix(in_re, in_im));
      if (out_valid && !out_stall) begin
        if (mixed_samples.size() == 0) begin
          report_mismatch("result with no transaction waiting, out_re", out_re, 0);
        end else begin
          want = mixed_samples.pop_front();
          if (out_re !== want.re) report_mismatch("out_re", out_re, want.re);
          if (out_im !== want.im) report_mismatch("out_im", out_im, want.im);
        end
      end
      pending = mixed_samples.size();
    end
  end

endmodule

// ===== verif/tb_recursive_quadrature_oscillator_mixer_core.sv =====
// Testbench top for the oscillator mixer: clock, reset, register writes, samples, verdict.
`timescale 1ns / 100ps

module tb_recursive_quadrature_oscillator_mixer_core
  import rqom_pkg::*;
;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int FB            = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 250;
  localparam int RANDOM_PHASES = 12;
  localparam int TAIL_CYCLES   = 40;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [FB+1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] in_re = '0;
  logic signed [SW-1:0] in_im = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] out_re;
  logic signed [SW-1:0] out_im;
  int                   pending;
  int                   mismatches;
  int                   cycles = 0;
  bit                   gaps_on = 1'b1;
  bit                   stalls_on = 1'b1;
  bit                   hold_req = 1'b0;

  recursive_quadrature_oscillator_mixer_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_re(in_re), .in_im(in_im),
    .out_valid(out_valid), .out_stall(out_stall), .out_re(out_re), .out_im(out_im)
  );

  rqom_mix_checker mix_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_re(in_re), .in_im(in_im),
    .out_valid(out_valid), .out_stall(out_stall), .out_re(out_re), .out_im(out_im),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_recursive_quadrature_oscillator_mixer_core: errors");
      $finish;
    end
  end

  // Mostly back to back, sometimes a few cycles, rarely a long gap.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2: return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  // Keep random upper bits on the flag registers; only bit zero counts.
  function automatic logic [FB+1:0] flag_word(input bit f);
    logic [FB+1:0] w;
    w = (FB+2)'($urandom);
    w[0] = f;
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FB+1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_mode(input int cs, input int sn, input int amp, input bit tone,
                          input bit real_in, input bit pass);
    write_reg(REG_COS_STEP, (FB+2)'(cs));
    write_reg(REG_SIN_STEP, (FB+2)'(sn));
    write_reg(REG_AMPLITUDE, (FB+2)'(amp));
    write_reg(REG_TEST_MODE, flag_word(tone));
    write_reg(REG_REAL_ONLY, flag_word(real_in));
    write_reg(REG_BYPASS, flag_word(pass));
  endtask

  task automatic pick_unit_step(output int cs, output int sn);
    cs = int'($urandom_range(0, 2 * (1 << FB))) - (1 << FB);
    sn = int'($sqrt(real'(longint'(1) << (2 * FB)) - real'(cs) * real'(cs)));
    if ($urandom_range(0, 1) == 1) sn = -sn;
  endtask

  // Called and returns at a falling edge; keep valid up for back-to-back transactions.
  task automatic push_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_re    = re;
    in_im    = im;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (hold_req) begin
        // long hold-off so the core backs up into its input
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
        @(negedge clk);
      end else if (!stalls_on) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int cs, sn, amp, n, r;
    bit tone, real_in, pass;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: bypass, complex
    push_sample(-32768, 32767);
    push_sample(32767, -32768);
    drain();

    // bypass with real-only: imaginary part dropped
    write_reg(REG_REAL_ONLY, flag_word(1'b1));
    push_sample(12345, -32768);
    push_sample(-1, 32767);
    drain();

    // out-of-range steps and amplitude clamp; spare indexes must not land anywhere
    set_mode(131071, -131072, 262143, 1'b1, 1'b0, 1'b0);
    write_reg(REG_SPARE_LO, (FB+2)'($urandom));
    write_reg(REG_SPARE_HI, (FB+2)'($urandom));
    push_sample(100, -100);
    push_sample(-32768, 32767);
    drain();

    // complex mix at full scale to drive the mix and output limits
    set_mode(46341, 46341, 65536, 1'b0, 1'b0, 1'b0);
    push_sample(-32768, -32768);
    push_sample(32767, 32767);
    push_sample(-32768, 32767);
    push_sample(0, 0);
    drain();

    set_mode(46341, -46341, 65536, 1'b0, 1'b1, 1'b0);
    push_sample(-32768, 5);
    push_sample(32767, -7);
    push_sample(1, 0);
    drain();

    set_mode(0, 65536, 0, 1'b1, 1'b1, 1'b0);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    drain();

    set_mode(0, 65536, 65536, 1'b1, 1'b0, 1'b0);
    push_sample(0, 0);
    push_sample(-1, -1);
    drain();

    set_mode(65536, 0, 0, 1'b0, 1'b0, 1'b0);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    drain();

    set_mode(-65536, 0, 32768, 1'b0, 1'b0, 1'b0);
    push_sample(32767, 32767);
    push_sample(-12345, 23456);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // raw register values only at the end: they can pin the phasor at its limit
      if (p == RANDOM_PHASES - 1) begin
        cs = $urandom_range(0, (1 << (FB + 2)) - 1);
        sn = $urandom_range(0, (1 << (FB + 2)) - 1);
      end else begin
        pick_unit_step(cs, sn);
      end
      r = $urandom_range(0, 9);
      if (r == 0) amp = 0;
      else if (r == 1) amp = 1 << FB;
      else if (r == 2) amp = $urandom_range(0, (1 << (FB + 2)) - 1);
      else amp = $urandom_range(0, 1 << FB);
      tone      = ($urandom_range(0, 2) == 0);
      real_in   = ($urandom_range(0, 2) == 0);
      pass      = ($urandom_range(0, 5) == 0);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      set_mode(cs, sn, amp, tone, real_in, pass);
      if (p == 1 || p == 7) hold_req = 1'b1;
      n = $urandom_range(70, 100);
      repeat (n) push_sample(rand_sample(), rand_sample());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_recursive_quadrature_oscillator_mixer_core: clean");
    end else begin
      $display("tb_recursive_quadrature_oscillator_mixer_core: errors");
    end
    $finish;
  end

endmodule

// ===== recursive_quadrature_oscillator_mixer_core.f =====
rtl/rqom_pkg.sv
rtl/rqom_ctrl.sv
rtl/rqom_datapath.sv
rtl/recursive_quadrature_oscillator_mixer_core.sv
verif/rqom_mix_checker.sv
verif/tb_recursive_quadrature_oscillator_mixer_core.sv
